### sv/mmpq_pkg.sv
package mmpq_pkg;

	// Operation codes carried in the opcode field.
	typedef enum logic [2:0] {
		OP_INSERT  = 3'd0,
		OP_POP_MIN = 3'd1,
		OP_POP_MAX = 3'd2,
		OP_UPDATE  = 3'd3,
		OP_CLEAR   = 3'd4
	} opcode_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_NOTLIVE = 2'd3
	} status_t;

	// Kind of sift that the heap engine runs on one heap.
	typedef enum logic [1:0] {
		M_UP   = 2'd0,
		M_UPDN = 2'd1,
		M_DN   = 2'd2
	} mode_t;

endpackage

### sv/min_max_priority_queue.sv
// Clears, unused opcodes and early rejects go from decode straight to the result; an update of a
// handle that has left the queue is rejected after its slot lookup. An insert sifts up in both
// heaps, an update sifts up in one heap and down in the other, and a pop sifts down and repairs the other heap.
// One operation at a time: a new beat is taken only after the result has been presented.
// Reset: arst_n clears the queue size, the handle counter and all control state at once;
// the memories are not cleared, since liveness is derived from the counter and the heaps.
module min_max_priority_queue #(
	parameter int CAPACITY = 1024,
	parameter int KEY_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// Fields from bit 0 up: opcode, item_handle, item_key.
	input  logic [((3 + $clog2(CAPACITY + 1) + KEY_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// Fields from bit 0 up: status, result_handle, result_key, live_count.
	output logic [((2 + 2 * $clog2(CAPACITY + 1) + KEY_BITS + 7) / 8) * 8 - 1:0] m_tdata
);
	import mmpq_pkg::*;

	localparam int HW = $clog2(CAPACITY + 1);
	localparam int KB = KEY_BITS;
	localparam int OW = 2 + 2 * HW + KB;
	localparam int OB = ((OW + 7) / 8) * 8;
	localparam logic [HW-1:0] CAP_H = HW'(CAPACITY);
	localparam logic [HW-1:0] ROOT = HW'(1);

	typedef enum logic [20:0] {
		S_IDLE   = 21'd1 << 0,
		S_DEC    = 21'd1 << 1,
		S_P0     = 21'd1 << 2,
		S_P1     = 21'd1 << 3,
		S_P2     = 21'd1 << 4,
		S_P3     = 21'd1 << 5,
		S_P4     = 21'd1 << 6,
		S_U0     = 21'd1 << 7,
		S_U1     = 21'd1 << 8,
		S_U2     = 21'd1 << 9,
		S_U3     = 21'd1 << 10,
		S_UP_RD  = 21'd1 << 11,
		S_UP_RK  = 21'd1 << 12,
		S_UP_CMP = 21'd1 << 13,
		S_DN_RD  = 21'd1 << 14,
		S_DN_RL  = 21'd1 << 15,
		S_DN_KL  = 21'd1 << 16,
		S_DN_CMP = 21'd1 << 17,
		S_FIN    = 21'd1 << 18,
		S_DONE   = 21'd1 << 19,
		S_SPARE  = 21'd1 << 20
	} state_t;

	typedef struct packed {
		logic                 dir;
		logic [HW-1:0]        pos;
		logic [HW-1:0]        h;
		logic signed [KB-1:0] k;
		mode_t                mode;
	} job_t;

	function automatic logic better(input logic dir, input logic signed [KB-1:0] a,
			input logic signed [KB-1:0] b);
		return dir ? (a > b) : (a < b);
	endfunction

	state_t               state_q;
	opcode_t              op_q;
	logic [HW-1:0]        hin_q;
	logic signed [KB-1:0] key_q;
	logic [HW-1:0]        size_q;
	logic [HW-1:0]        cnt_q;
	job_t                 jb_q;
	job_t                 pend_q;
	logic                 pend_v_q;
	logic                 moved_q;
	logic [HW-1:0]        b_q;
	logic [HW-1:0]        lh_q;
	logic [HW-1:0]        rh_q;
	logic signed [KB-1:0] kl_q;
	logic [HW-1:0]        ph_q;
	logic [HW-1:0]        opos_q;
	logic [HW-1:0]        ld_q;
	logic signed [KB-1:0] kld_q;
	logic [HW-1:0]        lo_q;
	logic [HW-1:0]        s_q;
	logic signed [KB-1:0] old_q;
	status_t              res_st_q;
	logic [HW-1:0]        res_h_q;
	logic signed [KB-1:0] res_k_q;
	logic                 m_tvalid_q;
	logic [OB-1:0]        m_tdata_q;

	// Heap arrays of both directions share one memory, as do the slot tables.
	logic [HW-1:0]        ord_mem  [2**(HW+1)];
	logic [HW-1:0]        slot_mem [2**(HW+1)];
	logic [KB-1:0]        key_mem  [2**HW];

	logic [HW:0]          ord_ra, ord_wa, slot_ra, slot_wa;
	logic [HW-1:0]        key_ra, key_wa;
	logic [HW-1:0]        ord_wd, slot_wd, ord_rd, slot_rd;
	logic [KB-1:0]        key_wd, key_rd_raw;
	logic signed [KB-1:0] key_rd;
	logic                 ord_we, slot_we, key_we;

	logic                 pdir;
	logic [HW:0]          lpos, rpos;
	logic                 l_ok, r_ok;
	logic                 up_better, sel_l, sel_r;
	logic signed [KB-1:0] kbest;
	logic [HW-1:0]        child;
	logic [HW-1:0]        cpos;
	logic [HW-1:0]        h_new;
	logic                 in_beat;

	assign key_rd   = key_rd_raw;
	assign pdir     = (op_q == OP_POP_MAX);
	assign lpos     = {jb_q.pos, 1'b0};
	assign rpos     = lpos + 1'b1;
	assign l_ok     = lpos <= {1'b0, size_q};
	assign r_ok     = rpos <= {1'b0, size_q};
	assign h_new    = cnt_q + 1'b1;
	assign in_beat  = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Comparisons of the element being sifted against its parent or children.
	always_comb begin
		up_better = better(jb_q.dir, jb_q.k, key_rd);
		sel_l     = l_ok && better(jb_q.dir, kl_q, jb_q.k);
		kbest     = sel_l ? kl_q : jb_q.k;
		sel_r     = r_ok && better(jb_q.dir, key_rd, kbest);
		child     = sel_r ? rh_q : lh_q;
		cpos      = sel_r ? rpos[HW-1:0] : lpos[HW-1:0];
	end

	// Memory addresses and write strobes for each step.
	always_comb begin
		ord_ra  = '0;
		slot_ra = '0;
		key_ra  = '0;
		ord_we  = 1'b0;
		ord_wa  = '0;
		ord_wd  = '0;
		slot_we = 1'b0;
		slot_wa = '0;
		slot_wd = '0;
		key_we  = 1'b0;
		key_wa  = '0;
		key_wd  = '0;
		unique case (state_q)
			S_DEC: begin
				if (op_q == OP_INSERT && cnt_q < CAP_H) begin
					key_we = 1'b1;
					key_wa = h_new;
					key_wd = key_q;
				end
			end
			S_P0: ord_ra = {pdir, ROOT};
			S_P1: begin
				slot_ra = {~pdir, ord_rd};
				key_ra  = ord_rd;
				ord_ra  = {pdir, size_q};
			end
			S_P2: begin
				ord_ra = {~pdir, size_q};
				key_ra = ord_rd;
			end
			S_P3: key_ra = ord_rd;
			S_U0: begin
				slot_ra = {1'b0, hin_q};
				key_ra  = hin_q;
			end
			S_U1: ord_ra = {1'b0, slot_rd};
			S_U2: slot_ra = {1'b1, hin_q};
			S_U3: begin
				key_we = 1'b1;
				key_wa = hin_q;
				key_wd = key_q;
			end
			S_UP_RD: ord_ra = {jb_q.dir, jb_q.pos >> 1};
			S_UP_RK: key_ra = ord_rd;
			S_UP_CMP: begin
				if (up_better) begin
					ord_we  = 1'b1;
					ord_wa  = {jb_q.dir, jb_q.pos};
					ord_wd  = b_q;
					slot_we = 1'b1;
					slot_wa = {jb_q.dir, b_q};
					slot_wd = jb_q.pos;
				end
			end
			S_DN_RD: ord_ra = {jb_q.dir, lpos[HW-1:0]};
			S_DN_RL: begin
				key_ra = ord_rd;
				ord_ra = {jb_q.dir, rpos[HW-1:0]};
			end
			S_DN_KL: key_ra = ord_rd;
			S_DN_CMP: begin
				if (sel_l || sel_r) begin
					ord_we  = 1'b1;
					ord_wa  = {jb_q.dir, jb_q.pos};
					ord_wd  = child;
					slot_we = 1'b1;
					slot_wa = {jb_q.dir, child};
					slot_wd = jb_q.pos;
				end
			end
			S_FIN: begin
				ord_we  = 1'b1;
				ord_wa  = {jb_q.dir, jb_q.pos};
				ord_wd  = jb_q.h;
				slot_we = 1'b1;
				slot_wa = {jb_q.dir, jb_q.h};
				slot_wd = jb_q.pos;
			end
			default: begin
			end
		endcase
	end

	// Synchronous memories with registered read data.
	always_ff @(posedge clk) begin
		if (ord_we) ord_mem[ord_wa] <= ord_wd;
		ord_rd <= ord_mem[ord_ra];
	end

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_wa] <= slot_wd;
		slot_rd <= slot_mem[slot_ra];
	end

	always_ff @(posedge clk) begin
		if (key_we) key_mem[key_wa] <= key_wd;
		key_rd_raw <= key_mem[key_ra];
	end

	// Operation sequencer and heap engine.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_INSERT;
			hin_q      <= '0;
			key_q      <= '0;
			size_q     <= '0;
			cnt_q      <= '0;
			jb_q       <= '0;
			pend_q     <= '0;
			pend_v_q   <= 1'b0;
			moved_q    <= 1'b0;
			b_q        <= '0;
			lh_q       <= '0;
			rh_q       <= '0;
			kl_q       <= '0;
			ph_q       <= '0;
			opos_q     <= '0;
			ld_q       <= '0;
			kld_q      <= '0;
			lo_q       <= '0;
			s_q        <= '0;
			old_q      <= '0;
			res_st_q   <= ST_OK;
			res_h_q    <= '0;
			res_k_q    <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_DONE) m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						op_q    <= opcode_t'(s_tdata[2:0]);
						hin_q   <= s_tdata[3 +: HW];
						key_q   <= s_tdata[3 + HW +: KB];
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					moved_q <= 1'b0;
					case (op_q)
						OP_INSERT: begin
							if (cnt_q >= CAP_H) begin
								res_st_q <= ST_FULL;
								res_h_q  <= '0;
								res_k_q  <= '0;
								state_q  <= S_DONE;
							end else begin
								cnt_q    <= h_new;
								size_q   <= size_q + 1'b1;
								jb_q     <= '{dir: 1'b0, pos: size_q + 1'b1, h: h_new,
									k: key_q, mode: M_UP};
								pend_q   <= '{dir: 1'b1, pos: size_q + 1'b1, h: h_new,
									k: key_q, mode: M_UP};
								pend_v_q <= 1'b1;
								res_st_q <= ST_OK;
								res_h_q  <= h_new;
								res_k_q  <= key_q;
								state_q  <= S_UP_RD;
							end
						end
						OP_POP_MIN, OP_POP_MAX: begin
							res_st_q <= (size_q == '0) ? ST_EMPTY : ST_OK;
							res_h_q  <= '0;
							res_k_q  <= '0;
							state_q  <= (size_q == '0) ? S_DONE : S_P0;
						end
						OP_UPDATE: begin
							res_st_q <= (hin_q == '0 || hin_q > cnt_q) ? ST_NOTLIVE : ST_OK;
							res_h_q  <= '0;
							res_k_q  <= '0;
							state_q  <= (hin_q == '0 || hin_q > cnt_q) ? S_DONE : S_U0;
						end
						OP_CLEAR: begin
							size_q   <= '0;
							cnt_q    <= '0;
							res_st_q <= ST_OK;
							res_h_q  <= '0;
							res_k_q  <= '0;
							state_q  <= S_DONE;
						end
						default: begin
							res_st_q <= ST_OK;
							res_h_q  <= '0;
							res_k_q  <= '0;
							state_q  <= S_DONE;
						end
					endcase
				end
				S_P0: state_q <= S_P1;
				S_P1: begin
					ph_q    <= ord_rd;
					state_q <= S_P2;
				end
				S_P2: begin
					opos_q  <= slot_rd;
					res_k_q <= key_rd;
					ld_q    <= ord_rd;
					state_q <= S_P3;
				end
				S_P3: begin
					lo_q    <= ord_rd;
					kld_q   <= key_rd;
					state_q <= S_P4;
				end
				S_P4: begin
					size_q   <= size_q - 1'b1;
					res_h_q  <= ph_q;
					jb_q     <= '{dir: pdir, pos: ROOT, h: ld_q, k: kld_q, mode: M_DN};
					pend_q   <= '{dir: ~pdir, pos: opos_q, h: lo_q, k: key_rd, mode: M_UPDN};
					pend_v_q <= (opos_q <= size_q - 1'b1);
					state_q  <= S_DN_RD;
				end
				S_U0: state_q <= S_U1;
				S_U1: begin
					s_q     <= slot_rd;
					old_q   <= key_rd;
					state_q <= S_U2;
				end
				S_U2: begin
					if (ord_rd != hin_q || s_q > size_q) begin
						res_st_q <= ST_NOTLIVE;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_U3;
					end
				end
				S_U3: begin
					res_h_q  <= hin_q;
					res_k_q  <= key_q;
					pend_v_q <= 1'b1;
					if (key_q < old_q) begin
						jb_q   <= '{dir: 1'b0, pos: s_q, h: hin_q, k: key_q, mode: M_UP};
						pend_q <= '{dir: 1'b1, pos: slot_rd, h: hin_q, k: key_q, mode: M_DN};
						state_q <= S_UP_RD;
					end else begin
						jb_q   <= '{dir: 1'b1, pos: slot_rd, h: hin_q, k: key_q, mode: M_UP};
						pend_q <= '{dir: 1'b0, pos: s_q, h: hin_q, k: key_q, mode: M_DN};
						state_q <= S_UP_RD;
					end
				end
				S_UP_RD: begin
					if (jb_q.pos == ROOT) begin
						state_q <= (jb_q.mode == M_UPDN && !moved_q) ? S_DN_RD : S_FIN;
					end else begin
						state_q <= S_UP_RK;
					end
				end
				S_UP_RK: begin
					b_q     <= ord_rd;
					state_q <= S_UP_CMP;
				end
				S_UP_CMP: begin
					if (up_better) begin
						jb_q.pos <= jb_q.pos >> 1;
						moved_q  <= 1'b1;
						state_q  <= S_UP_RD;
					end else begin
						state_q <= (jb_q.mode == M_UPDN && !moved_q) ? S_DN_RD : S_FIN;
					end
				end
				S_DN_RD: state_q <= l_ok ? S_DN_RL : S_FIN;
				S_DN_RL: begin
					lh_q    <= ord_rd;
					state_q <= S_DN_KL;
				end
				S_DN_KL: begin
					kl_q    <= key_rd;
					rh_q    <= ord_rd;
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (sel_l || sel_r) begin
						jb_q.pos <= cpos;
						state_q  <= S_DN_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					moved_q <= 1'b0;
					if (pend_v_q) begin
						jb_q     <= pend_q;
						pend_v_q <= 1'b0;
						state_q  <= (pend_q.mode == M_DN) ? S_DN_RD : S_UP_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= OB'({size_q, res_k_q, res_h_q, res_st_q});
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The queue never holds more entries than were inserted since the last clear.
	assert property (@(posedge clk) disable iff (!arst_n) size_q <= cnt_q)
		else $error("queue size exceeds handle counter");

	// An accepted beat is always decoded in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n) in_beat |=> state_q == S_DEC)
		else $error("accepted beat not decoded");

	// The heap engine never works on position zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP_RD || state_q == S_DN_RD || state_q == S_FIN) |-> jb_q.pos != '0)
		else $error("sift at position zero");

endmodule
